// File: hw/rtl/differential_drive_odometry_macros.svh
// Assertion macros for the differential drive odometry checker.
// Included by the checker file; no other dependencies.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DDO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define DDO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ddo_pkg.sv
// Shared types, constants and the arctangent table for the odometry block.
// No dependencies.
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int MUL_W            = 34;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [29:0]        INV_TWO_PI_Q32  = 30'd683565276;
    localparam logic [19:0]        USEC_PER_SEC    = 20'd1000000;

    localparam logic [31:0] LEFT_MPP_RST  = 32'd16777216;
    localparam logic [31:0] RIGHT_MPP_RST = 32'd16777216;
    localparam logic [31:0] INV_SEP_RST   = 32'd29351323;

    // configuration register indexes
    localparam logic [2:0] CFG_LEFT_MPP  = 3'd0;
    localparam logic [2:0] CFG_RIGHT_MPP = 3'd1;
    localparam logic [2:0] CFG_INV_SEP   = 3'd2;
    localparam logic [2:0] CFG_LEFT_REV  = 3'd3;
    localparam logic [2:0] CFG_RIGHT_REV = 3'd4;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic        [31:0] stamp_us;
    } sample_t;

    typedef struct packed {
        logic        [31:0] out_stamp;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] speed;
        logic signed [31:0] yaw_rate;
        logic               first_sample;
    } result_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/differential_drive_odometry.sv
// Differential drive wheel odometry, top level: sequencer and state.
// Depends on ddo_pkg, ddo_mul, ddo_cordic and ddo_div.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+--------------------
//   sample   | in        | sample_valid/sample_stall | ddo_pkg::sample_t
//   result   | out       | result_valid/result_stall | ddo_pkg::result_t
//   cfg      | in        | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// One item at a time. The first item after reset goes straight to the pass
// for the reported heading. A regular item runs two CORDIC passes (midpoint
// heading, then the reported heading) and two 32-step divisions (linear and
// angular rate); a rate whose quotient overflows skips its division steps.
// All products go through the single shared multiplier. An item with a
// non-increasing stamp only re-latches.
// rst_n clears the pose, the latched sample and the registers to defaults.
// sample_stall and !cfg_ready are high while an item is in work; a finished
// result sits in the output register until taken, and the next item is
// accepted meanwhile.
`timescale 1ns / 1ps

module differential_drive_odometry #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ddo_pkg::ANGLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  ddo_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output ddo_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import ddo_pkg::*;

    localparam int FB  = ANGLE_BITS + 2;      // fine angle bits per turn
    localparam int HSR = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int HSL = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_ML, S_MR, S_DR, S_DS, S_TH, S_TW, S_AL, S_AH, S_AU, S_CW,
        S_PX, S_PY, S_PU, S_RL, S_RH, S_RN, S_RW, S_EC, S_EW, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0] lmpp_reg, rmpp_reg, inv_sep_reg;
    logic        lrev_reg, rrev_reg;

    // persistent state
    logic               init_reg;
    logic [31:0]        last_l_reg, last_r_reg, last_stamp_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [ANGLE_BITS-1:0] yaw_reg;

    // per-item working registers
    logic signed [31:0] dlp_reg, drp_reg, dl_reg, dr_reg, ds_reg, dd_reg;
    logic [31:0]        dt_reg, stamp_reg;
    logic signed [63:0] dth_reg;
    logic [63:0]        p1_reg;
    logic [FB:0]        da_reg;
    logic signed [33:0] cos_reg, sin_reg;
    logic [39:0]        rate_m_reg;
    logic               rate_neg_reg, rate_sel_reg, first_reg;
    logic [39:0]        pl_reg;
    logic signed [31:0] lin_reg, ang_reg;
    logic signed [15:0] qz_reg, qw_reg;

    logic    result_valid_reg;
    result_t result_reg;

    // shared units
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic                      cordic_start, cordic_done;
    logic [FB-1:0]             cordic_fine;
    logic signed [33:0]        cordic_cos, cordic_sin;
    logic                      div_start, div_done, div_ovf;
    logic [31:0]               div_quo;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sh0_0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -68'sh0_0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        return (v == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v;
    endfunction

    // (v + 2^15) >>> 16 clamped to +-1.0 in Q1.14
    function automatic logic signed [15:0] quat_part(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [18:0] q;
        logic signed [15:0] r;
        t = 35'(v) + 35'sd32768;
        q = t[34:16];
        if (q > 19'sd16384)
            r = 16'sd16384;
        else if (q < -19'sd16384)
            r = -16'sd16384;
        else
            r = q[15:0];
        return r;
    endfunction

    logic        sample_acc, result_take, result_load;
    logic [31:0] dtv;
    logic        dt_ok;

    assign sample_stall = (state_reg != S_IDLE);
    assign sample_acc   = sample_valid && !sample_stall;
    assign dtv          = sample.stamp_us - last_stamp_reg;
    assign dt_ok        = !dtv[31] && (dtv != '0);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign result_take  = result_valid_reg && !result_stall;
    assign result_load  = (state_reg == S_OUT) && (!result_valid_reg || !result_stall);

    // travel after scaling and reversal
    logic signed [31:0] wheel_scaled, wheel_next;
    logic               wheel_rev;
    assign wheel_scaled = sat32(mul_p >>> 8);
    assign wheel_rev    = (state_reg == S_MR) ? lrev_reg : rrev_reg;
    assign wheel_next   = wheel_rev ? neg_sat(wheel_scaled) : wheel_scaled;

    logic signed [32:0] ds_sum, dd_diff;
    assign ds_sum  = 33'(dl_reg) + 33'(dr_reg);
    assign dd_diff = 33'(dr_reg) - 33'(dl_reg);

    // rotation in fine turn units
    logic signed [47:0] rot_a;
    logic [63:0]        rot_u;
    logic [FB:0]        da_next;
    logic [FB-1:0]      mid_angle, yaw_fine;
    assign rot_a     = dth_reg[63:16];
    assign rot_u     = p1_reg + {mul_p[39:0], 24'b0};
    assign da_next   = rot_u[56 -: FB + 1];
    assign mid_angle = {yaw_reg, 2'b00} + da_next[FB:1];
    assign yaw_fine  = {yaw_reg, 2'b00} + da_reg[FB-1:0] + FB'(2);

    // position update
    logic signed [38:0] pos_sum;
    logic signed [31:0] pos_cur;
    assign pos_cur = (state_reg == S_PY) ? pos_x_reg : pos_y_reg;
    assign pos_sum = 39'(pos_cur) + 39'(mul_p >>> 30);

    logic [59:0] rate_n;
    assign rate_n = 60'(pl_reg) + {mul_p[39:0], 20'b0};

    logic signed [31:0] rate_out;
    always_comb
    begin
        if (rate_neg_reg)
            rate_out = (div_ovf || div_quo[31]) ? 32'sh8000_0000 : -$signed(div_quo);
        else
            rate_out = (div_ovf || div_quo[31]) ? 32'sh7FFF_FFFF : $signed(div_quo);
    end

    logic [31:0] yaw_ext;
    logic [15:0] heading_val;
    assign yaw_ext     = 32'(yaw_reg);
    assign heading_val = 16'((yaw_ext >> HSR) << HSL);

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ML:
            begin
                mul_a = MUL_W'(dlp_reg);
                mul_b = $signed({2'b00, lmpp_reg});
            end
            S_MR:
            begin
                mul_a = MUL_W'(drp_reg);
                mul_b = $signed({2'b00, rmpp_reg});
            end
            S_TH:
            begin
                mul_a = MUL_W'(dd_reg);
                mul_b = $signed({2'b00, inv_sep_reg});
            end
            S_AL:
            begin
                mul_a = $signed({10'b0, rot_a[23:0]});
                mul_b = $signed({4'b0, INV_TWO_PI_Q32});
            end
            S_AH:
            begin
                mul_a = MUL_W'($signed(rot_a[47:24]));
                mul_b = $signed({4'b0, INV_TWO_PI_Q32});
            end
            S_PX:
            begin
                mul_a = MUL_W'(ds_reg);
                mul_b = cos_reg;
            end
            S_PY:
            begin
                mul_a = MUL_W'(ds_reg);
                mul_b = sin_reg;
            end
            S_RL:
            begin
                mul_a = $signed({14'b0, rate_m_reg[19:0]});
                mul_b = $signed({14'b0, USEC_PER_SEC});
            end
            S_RH:
            begin
                mul_a = $signed({14'b0, rate_m_reg[39:20]});
                mul_b = $signed({14'b0, USEC_PER_SEC});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign cordic_start = (state_reg == S_AU) || (state_reg == S_EC);
    assign cordic_fine  = (state_reg == S_EC) ? {yaw_reg[ANGLE_BITS-1], yaw_reg, 1'b0}
                                              : mid_angle;
    assign div_start    = (state_reg == S_RN);

    ddo_mul u_mul (
        .clk   (clk),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FINE_BITS    (FB)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .fine    (cordic_fine),
        .done    (cordic_done),
        .cos_val (cordic_cos),
        .sin_val (cordic_sin)
    );

    ddo_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi ({4'b0, rate_n[59:32]}),
        .num_lo (rate_n[31:0]),
        .den    (dt_reg),
        .done   (div_done),
        .ovf    (div_ovf),
        .quo    (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            lmpp_reg         <= LEFT_MPP_RST;
            rmpp_reg         <= RIGHT_MPP_RST;
            inv_sep_reg      <= INV_SEP_RST;
            lrev_reg         <= 1'b0;
            rrev_reg         <= 1'b0;
            init_reg         <= 1'b0;
            last_l_reg       <= '0;
            last_r_reg       <= '0;
            last_stamp_reg   <= '0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            yaw_reg          <= '0;
            dlp_reg          <= '0;
            drp_reg          <= '0;
            dl_reg           <= '0;
            dr_reg           <= '0;
            ds_reg           <= '0;
            dd_reg           <= '0;
            dt_reg           <= '0;
            stamp_reg        <= '0;
            dth_reg          <= '0;
            p1_reg           <= '0;
            da_reg           <= '0;
            cos_reg          <= '0;
            sin_reg          <= '0;
            rate_m_reg       <= '0;
            rate_neg_reg     <= 1'b0;
            rate_sel_reg     <= 1'b0;
            first_reg        <= 1'b0;
            pl_reg           <= '0;
            lin_reg          <= '0;
            ang_reg          <= '0;
            qz_reg           <= '0;
            qw_reg           <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LEFT_MPP:  lmpp_reg    <= cfg_data;
                    CFG_RIGHT_MPP: rmpp_reg    <= cfg_data;
                    CFG_INV_SEP:   inv_sep_reg <= cfg_data;
                    CFG_LEFT_REV:  lrev_reg    <= cfg_data[0];
                    CFG_RIGHT_REV: rrev_reg    <= cfg_data[0];
                    default:       ;
                endcase
            end

            // a load always finds the register empty or being taken
            if (result_load)
                result_valid_reg <= 1'b1;
            else if (result_take)
                result_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_acc)
                    begin
                        last_l_reg     <= sample.left_count;
                        last_r_reg     <= sample.right_count;
                        last_stamp_reg <= sample.stamp_us;
                        stamp_reg      <= sample.stamp_us;
                        dlp_reg        <= sample.left_count - last_l_reg;
                        drp_reg        <= sample.right_count - last_r_reg;
                        dt_reg         <= dtv;
                        if (!init_reg)
                        begin
                            // first item: report pose with zero rates
                            init_reg  <= 1'b1;
                            first_reg <= 1'b1;
                            lin_reg   <= '0;
                            ang_reg   <= '0;
                            state_reg <= S_EC;
                        end
                        else if (dt_ok)
                        begin
                            first_reg <= 1'b0;
                            state_reg <= S_ML;
                        end
                    end
                end
                S_ML: state_reg <= S_MR;
                S_MR:
                begin
                    dl_reg    <= wheel_next;
                    state_reg <= S_DR;
                end
                S_DR:
                begin
                    dr_reg    <= wheel_next;
                    state_reg <= S_DS;
                end
                S_DS:
                begin
                    ds_reg    <= ds_sum[32:1];
                    dd_reg    <= sat32(68'(dd_diff));
                    state_reg <= S_TH;
                end
                S_TH: state_reg <= S_TW;
                S_TW:
                begin
                    dth_reg   <= mul_p[63:0];
                    state_reg <= S_AL;
                end
                S_AL: state_reg <= S_AH;
                S_AH:
                begin
                    p1_reg    <= mul_p[63:0];
                    state_reg <= S_AU;
                end
                S_AU:
                begin
                    // CORDIC starts here on the midpoint angle
                    da_reg    <= da_next;
                    state_reg <= S_CW;
                end
                S_CW:
                begin
                    if (cordic_done)
                    begin
                        cos_reg   <= cordic_cos;
                        sin_reg   <= cordic_sin;
                        state_reg <= S_PX;
                    end
                end
                S_PX: state_reg <= S_PY;
                S_PY:
                begin
                    pos_x_reg <= sat32(68'(pos_sum));
                    state_reg <= S_PU;
                end
                S_PU:
                begin
                    pos_y_reg    <= sat32(68'(pos_sum));
                    yaw_reg      <= yaw_fine[FB-1:2];
                    rate_sel_reg <= 1'b0;
                    rate_neg_reg <= ds_reg[31];
                    rate_m_reg   <= ds_reg[31] ? 40'(-40'(ds_reg)) : 40'(ds_reg);
                    state_reg    <= S_RL;
                end
                S_RL: state_reg <= S_RH;
                S_RH:
                begin
                    pl_reg    <= mul_p[39:0];
                    state_reg <= S_RN;
                end
                S_RN: state_reg <= S_RW;
                S_RW:
                begin
                    if (div_done)
                    begin
                        if (!rate_sel_reg)
                        begin
                            lin_reg      <= rate_out;
                            rate_sel_reg <= 1'b1;
                            rate_neg_reg <= dth_reg[63];
                            rate_m_reg   <= dth_reg[63] ? 40'(-dth_reg[63:24])
                                                        : 40'(dth_reg[63:24]);
                            state_reg    <= S_RL;
                        end
                        else
                        begin
                            ang_reg   <= rate_out;
                            state_reg <= S_EC;
                        end
                    end
                end
                S_EC: state_reg <= S_EW;
                S_EW:
                begin
                    if (cordic_done)
                    begin
                        qz_reg    <= quat_part(cordic_sin);
                        qw_reg    <= quat_part(cordic_cos);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (result_load)
                    begin
                        result_reg.out_stamp    <= stamp_reg;
                        result_reg.pos_x        <= pos_x_reg;
                        result_reg.pos_y        <= pos_y_reg;
                        result_reg.heading      <= $signed(heading_val);
                        result_reg.quat_z       <= qz_reg;
                        result_reg.quat_w       <= qw_reg;
                        result_reg.speed        <= lin_reg;
                        result_reg.yaw_rate     <= ang_reg;
                        result_reg.first_sample <= first_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: hw/rtl/ddo_mul.sv
// Shared signed 34x34 multiplier with registered product.
// Uses ddo_pkg for the operand width.
`timescale 1ns / 1ps

module ddo_mul (
    input  logic                             clk,
    input  logic signed [ddo_pkg::MUL_W-1:0] a,
    input  logic signed [ddo_pkg::MUL_W-1:0] b,
    output logic signed [2*ddo_pkg::MUL_W-1:0] p_reg
);
    import ddo_pkg::*;

    logic signed [2*MUL_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

// File: hw/rtl/ddo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Uses ddo_pkg for the gain and the arctangent table.
`timescale 1ns / 1ps

module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF,
    parameter int FINE_BITS    = ddo_pkg::ANGLE_BITS_DEF + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [FINE_BITS-1:0] fine,
    output logic                 done,
    output logic signed [33:0]   cos_val,
    output logic signed [33:0]   sin_val
);
    import ddo_pkg::*;

    localparam int NS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int CW = $clog2(NS);

    logic                busy_reg, done_reg, flip_reg;
    logic [CW-1:0]       step_reg;
    logic signed [33:0]  x_reg, y_reg, z_reg;

    logic [31:0]         z0, z0_rot, z0_fold;
    logic                flip0;
    logic signed [33:0]  x_sh, y_sh, atan_v;

    assign z0      = {fine, {(32 - FINE_BITS){1'b0}}};
    assign z0_rot  = z0 + 32'h4000_0000;
    assign flip0   = z0_rot[31];
    assign z0_fold = flip0 ? (z0 + 32'h8000_0000) : z0;

    assign x_sh   = x_reg >>> step_reg;
    assign y_sh   = y_reg >>> step_reg;
    assign atan_v = $signed({2'b00, atan_turn(5'(step_reg))});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            flip_reg <= 1'b0;
            step_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                flip_reg <= flip0;
                step_reg <= '0;
                x_reg    <= CORDIC_GAIN_Q30;
                y_reg    <= '0;
                z_reg    <= 34'($signed(z0_fold));
            end
            else if (busy_reg)
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                    z_reg <= z_reg + atan_v;
                end
                if (step_reg == CW'(NS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign cos_val = flip_reg ? -x_reg : x_reg;
    assign sin_val = flip_reg ? -y_reg : y_reg;

endmodule

// File: hw/rtl/ddo_div.sv
// Restoring divider, one quotient bit per cycle, 64/32 with 32-bit quotient.
// Flags overflow when the quotient would not fit in 32 bits. No dependencies.
`timescale 1ns / 1ps

module ddo_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num_hi,
    input  logic [31:0] num_lo,
    input  logic [31:0] den,
    output logic        done,
    output logic        ovf,
    output logic [31:0] quo
);
    logic        busy_reg, done_reg, ovf_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg, q_reg;
    logic [32:0] trial, diff;

    assign trial = {rem_reg, q_reg[31]};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg <= num_hi;
                q_reg   <= num_lo;
                cnt_reg <= '0;
                if (num_hi >= den)
                begin
                    ovf_reg  <= 1'b1;
                    done_reg <= 1'b1;
                end
                else
                begin
                    ovf_reg  <= 1'b0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (!diff[32])
                begin
                    rem_reg <= diff[31:0];
                    q_reg   <= {q_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[31:0];
                    q_reg   <= {q_reg[30:0], 1'b0};
                end
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = q_reg;

endmodule

// File: hw/rtl/ddo_checker.sv
// Port-level checker for the odometry block, bound to the top level.
// Depends on ddo_pkg and differential_drive_odometry_macros.svh.
`timescale 1ns / 1ps
`include "differential_drive_odometry_macros.svh"

module ddo_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             sample_stall,
    input logic             result_valid,
    input logic             result_stall,
    input ddo_pkg::result_t result
);
    import ddo_pkg::*;

    logic stalled, first_out, rates_zero, quat_ok;

    assign stalled    = result_valid && result_stall;
    assign first_out  = result_valid && result.first_sample;
    assign rates_zero = (result.speed == 32'sd0) && (result.yaw_rate == 32'sd0);
    assign quat_ok    = (result.quat_z <= 16'sd16384) && (result.quat_z >= -16'sd16384)
                     && (result.quat_w <= 16'sd16384) && (result.quat_w >= -16'sd16384);

    `DDO_ASSERT_NEXT(a_result_hold, clk, rst_n, stalled, result_valid && $stable(result), "held item changed")
    `DDO_ASSERT_NOW(a_first_zero_rate, clk, rst_n, first_out, rates_zero, "first item has nonzero rate")
    `DDO_ASSERT_NOW(a_quat_range, clk, rst_n, result_valid, quat_ok, "quaternion out of range")
    `DDO_ASSERT_NOW(a_result_src, clk, rst_n, $rose(result_valid), $past(sample_stall), "item without work")

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: sim/tb_differential_drive_odometry.sv
// Self-checking testbench for differential_drive_odometry: encoder samples in,
// pose and velocity items out, checked against an in-bench fixed-point predictor.
// Depends on ddo_pkg and the differential_drive_odometry RTL.
`timescale 1ns / 1ps

module tb_differential_drive_odometry;

    import ddo_pkg::*;

    // No-accept watchdog limit.
    localparam int IDLE_LIMIT   = 4000;
    // Cycles to let the block finish an item that gives no result.
    localparam int SETTLE_TICKS = 300;
    localparam int RANDOM_ITEMS = 1950;
    localparam int FINE_MASK    = 32'h3FFFF;     // ANGLE_BITS + 2 bits per turn
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint unsigned TURN_PER_RAD = 64'd683565276;
    localparam longint unsigned MICROS = 64'd1000000;

    // atan(2^-i) in 2^-32 turn units, enough for 16 rotations
    localparam logic [31:0] ATAN_STEP [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    sample_t     sample = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_LEFT_MPP;
    logic [31:0] cfg_data = '0;

    differential_drive_odometry u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: register copy and odometry state
    // ------------------------------------------------------------------
    logic [31:0] mpp_left, mpp_right, inv_sep;
    logic        rev_left, rev_right;
    logic        odo_init;
    logic [31:0] last_left, last_right, last_stamp;
    logic [31:0] pose_x, pose_y;
    logic [15:0] yaw;

    sample_t pending_samples[$];
    result_t expected_poses[$];
    int      fail_count = 0;

    function automatic longint sext32(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // sin/cos of a fine angle (2^18 per turn), Q.30, folded by a half turn
    function automatic void sincos_fine(input logic [31:0] fine,
                                        output longint c, output longint s);
        logic [31:0] z;
        logic [31:0] probe;
        logic        flip;
        longint      x, y, zz, nx;
        z = fine << 14;
        probe = z + 32'h40000000;
        flip = probe[31];
        if (flip) z = z + 32'h80000000;
        zz = sext32(z);
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (zz >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                zz = zz - longint'(ATAN_STEP[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                zz = zz + longint'(ATAN_STEP[i]);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // Q16.16 value per microsecond step -> per second, truncated, saturated
    function automatic logic [31:0] per_second(input longint v, input logic [31:0] dt);
        longint unsigned m, q, r, mag, d;
        logic [31:0]     neg_mag;
        d = longint'(dt);
        m = (v < 0) ? longint'(-v) : longint'(v);
        q = m / d;
        r = m % d;
        mag = (q >= 64'h1_0000_0000) ? 64'h1_0000_0000 : q * MICROS + (r * MICROS) / d;
        if (v < 0) begin
            neg_mag = 32'd0 - mag[31:0];
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : neg_mag;
        end
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [15:0] quat_q14(input longint v);
        longint q;
        q = (v + 32768) >>> 16;
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        return q[15:0];
    endfunction

    function automatic result_t pose_item(input logic [31:0] st, input logic [31:0] lin,
                                          input logic [31:0] ang, input logic first);
        result_t     r;
        longint      c, s, sy;
        logic [31:0] fine;
        sy = longint'($signed(yaw));
        fine = 32'(sy * 2) & FINE_MASK;
        sincos_fine(fine, c, s);
        r.out_stamp    = st;
        r.pos_x        = pose_x;
        r.pos_y        = pose_y;
        r.heading      = yaw;
        r.quat_z       = quat_q14(s);
        r.quat_w       = quat_q14(c);
        r.speed        = lin;
        r.yaw_rate     = ang;
        r.first_sample = first;
        return r;
    endfunction

    // Advances the odometry state for one sample; returns 1 if it yields a pose item.
    function automatic bit odometry_step(input sample_t smp, output result_t r);
        logic [31:0]     d_st, d_l, d_r, dt, da, mid, yfine;
        longint          dtv, dl, dr, ds, dd, dth40, c, s;
        longint unsigned turn;
        r = '0;
        if (!odo_init) begin
            last_left  = smp.left_count;
            last_right = smp.right_count;
            last_stamp = smp.stamp_us;
            odo_init   = 1'b1;
            r = pose_item(smp.stamp_us, 32'd0, 32'd0, 1'b1);
            return 1'b1;
        end
        d_st = smp.stamp_us - last_stamp;
        d_l  = smp.left_count - last_left;
        d_r  = smp.right_count - last_right;
        last_left  = smp.left_count;
        last_right = smp.right_count;
        last_stamp = smp.stamp_us;
        dtv = sext32(d_st);
        if (dtv <= 0) return 1'b0;
        dt = d_st;

        dl = clamp32((sext32(d_l) * longint'(mpp_left)) >>> 8);
        dr = clamp32((sext32(d_r) * longint'(mpp_right)) >>> 8);
        if (rev_left) dl = clamp32(-dl);
        if (rev_right) dr = clamp32(-dr);
        ds = (dl + dr) >>> 1;
        dd = clamp32(dr - dl);
        dth40 = dd * longint'(inv_sep);

        // rotation in turns, 56 fraction bits, keep 19 bits of the fine angle
        turn = longint'(dth40 >>> 16) * TURN_PER_RAD;
        da = {13'd0, turn[56:38]};
        mid = ((32'(yaw) << 2) + (da >> 1)) & FINE_MASK;
        sincos_fine(mid, c, s);
        pose_x = 32'(clamp32(sext32(pose_x) + ((ds * c) >>> 30)));
        pose_y = 32'(clamp32(sext32(pose_y) + ((ds * s) >>> 30)));
        yfine = (32'(yaw) << 2) + da;
        yaw = 16'((yfine + 32'd2) >> 2);

        r = pose_item(smp.stamp_us, per_second(ds, dt), per_second(dth40 >>> 24, dt), 1'b0);
        return 1'b1;
    endfunction

    initial begin
        mpp_left   = LEFT_MPP_RST;
        mpp_right  = RIGHT_MPP_RST;
        inv_sep    = INV_SEP_RST;
        rev_left   = 1'b0;
        rev_right  = 1'b0;
        odo_init   = 1'b0;
        last_left  = '0;
        last_right = '0;
        last_stamp = '0;
        pose_x     = '0;
        pose_y     = '0;
        yaw        = '0;
    end

    // ------------------------------------------------------------------
    // Sample driver: pops pending items, random gap after each accepted one
    // ------------------------------------------------------------------
    int sample_gap = 0;
    int items_in = 0;
    bit no_gaps = 1'b0;

    always @(posedge clk) begin : sample_driver
        logic    next_valid;
        result_t pose;
        if (!rst_n) begin
            sample_valid <= 1'b0;
        end else begin
            next_valid = sample_valid;
            if (sample_valid && !sample_stall) begin
                if (odometry_step(sample, pose)) expected_poses.push_back(pose);
                items_in++;
                // every so often switch between back-to-back and gappy traffic
                if (items_in % 97 == 0) no_gaps = ($urandom_range(0, 2) == 0);
                sample_gap = no_gaps ? 0 : $urandom_range(0, 13);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (sample_gap > 0) begin
                    sample_gap--;
                end else if (pending_samples.size() > 0) begin
                    sample <= pending_samples.pop_front();
                    next_valid = 1'b1;
                end
            end
            sample_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random stall before each item, field-by-field compare
    // ------------------------------------------------------------------
    int result_hold = 0;
    int items_out = 0;

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : result_monitor
        result_t want;
        if (!rst_n) begin
            result_stall <= 1'b0;
        end else begin
            if (result_valid && !result_stall) begin
                items_out++;
                if (expected_poses.size() == 0) begin
                    $error("unexpected result item, stamp %0d", result.out_stamp);
                    fail_count++;
                end else begin
                    want = expected_poses.pop_front();
                    check_field("out_stamp", want.out_stamp, result.out_stamp);
                    check_field("pos_x", want.pos_x, result.pos_x);
                    check_field("pos_y", want.pos_y, result.pos_y);
                    check_field("heading", want.heading, result.heading);
                    check_field("quat_z", want.quat_z, result.quat_z);
                    check_field("quat_w", want.quat_w, result.quat_w);
                    check_field("speed", want.speed, result.speed);
                    check_field("yaw_rate", want.yaw_rate, result.yaw_rate);
                    check_field("first_sample", want.first_sample, result.first_sample);
                end
                result_hold = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 13);
            end
            if (result_hold > 0) begin
                result_hold--;
                result_stall <= 1'b1;
            end else begin
                result_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run after too long without any handshake
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk) begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [31:0] gen_left = '0, gen_right = '0, gen_stamp = '0;

    task automatic push_sample(input logic [31:0] l, input logic [31:0] r,
                               input logic [31:0] st);
        sample_t smp;
        smp.left_count  = l;
        smp.right_count = r;
        smp.stamp_us    = st;
        pending_samples.push_back(smp);
        gen_left  = l;
        gen_right = r;
        gen_stamp = st;
    endtask

    // Move both wheels by the given deltas and step the stamp by dt.
    task automatic push_motion(input int dl, input int dr, input int unsigned dt);
        push_sample(gen_left + dl, gen_right + dr, gen_stamp + dt);
    endtask

    task automatic push_random_sample();
        int      kind;
        int      span;
        kind = $urandom_range(0, 99);
        span = ($urandom_range(0, 3) == 0) ? 200000 : 3000;
        if (kind < 78) begin
            push_motion($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                        $urandom_range(1, 20000));
        end else if (kind < 86) begin
            // stamp repeats or steps back: state re-latches, no item out
            push_motion($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                        -$urandom_range(0, 5000));
        end else if (kind < 94) begin
            // large jumps: wrapping deltas and long steps
            push_sample($urandom, $urandom, gen_stamp + $urandom_range(1, 32'h7FFF_FFFF));
        end else begin
            push_sample($urandom, $urandom, $urandom);
        end
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_LEFT_MPP:  mpp_left  = data;
            CFG_RIGHT_MPP: mpp_right = data;
            CFG_INV_SEP:   inv_sep   = data;
            CFG_LEFT_REV:  rev_left  = data[0];
            CFG_RIGHT_REV: rev_right = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [31:0] ml, input logic [31:0] mr,
                                input logic [31:0] isep, input logic [31:0] rl,
                                input logic [31:0] rr);
        cfg_write(CFG_LEFT_MPP, ml);
        cfg_write(CFG_RIGHT_MPP, mr);
        cfg_write(CFG_INV_SEP, isep);
        cfg_write(CFG_LEFT_REV, rl);
        cfg_write(CFG_RIGHT_REV, rr);
    endtask

    // Wait until all items are sent and answered, then let a trailing
    // no-result item finish inside the block.
    task automatic drain();
        while (pending_samples.size() > 0 || sample_valid) @(posedge clk);
        while (expected_poses.size() > 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset geometry. First item latches and reports zero rates.
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
        push_motion(10, 30, 32'h20);               // stamp wraps through zero
        push_motion(5, 5, 0);                      // repeated stamp
        push_motion(-3, 4, -100);                  // stamp goes back
        push_motion(0, 0, 1);                      // standing still
        push_motion(32'h7FFF_FFFF, 32'h8000_0000, 1);  // extreme travel, dt of 1
        push_motion(7, 7, 32'h7FFF_FFFF);          // longest forward step
        push_motion(1, 1, 32'h8000_0000);          // step reads as negative
        for (int i = 0; i < 6; i++) push_motion(-2, 2, 1000);  // spin in place
        push_motion(100, 100, 500);                // straight
        drain();

        // Extremes: full-scale wheel constants, both wheels reversed
        set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        cfg_write(3'd5, $urandom);                 // unmapped indexes are ignored
        cfg_write(3'd7, $urandom);
        push_motion(32'h7FFF_FFFF, -32'h7FFF_FFFF, 1);
        push_motion(-1, 1, 3);
        push_motion(1, 1, 10);
        drain();

        // Zero constants: no travel and no rotation
        set_geometry(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        push_motion(1000, -1000, 50);
        push_motion(32'h8000_0000, 5, 60);
        drain();

        // Random phases through several geometries
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_geometry(LEFT_MPP_RST, RIGHT_MPP_RST, INV_SEP_RST, 0, 0);
                1: set_geometry(32'd1, 32'd1, 32'd1, 1, 0);
                2: set_geometry(32'h0001_0000, 32'h0001_2000, INV_SEP_RST, 0, 1);
                3: set_geometry(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1, 1);
                default: set_geometry($urandom_range(0, 32'h0400_0000),
                                      $urandom_range(0, 32'h0400_0000),
                                      $urandom_range(1, 32'h1000_0000),
                                      $urandom, $urandom);
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) push_random_sample();
            drain();
        end

        if (expected_poses.size() > 0) begin
            $error("%0d result items never arrived", expected_poses.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
